// File: design/rpag_pkg.sv
// Shared types, constants and the glyph ramp table for the RGB pixel to ASCII glyph block.
`timescale 1ns / 1ps

package rpag_pkg;

   localparam int unsigned CHAN_W   = 8;
   localparam int unsigned GLYPH_W  = 7;
   localparam int unsigned COLOUR_W = 4;

   localparam logic [8:0]  LUMA_RED_WEIGHT   = 9'd299;
   localparam logic [9:0]  LUMA_GREEN_WEIGHT = 10'd587;
   localparam logic [6:0]  LUMA_BLUE_WEIGHT  = 7'd114;

   // Reciprocal of 1000 scaled by 2**26; exact floor for every weighted sum up to 255000.
   localparam logic [16:0] RECIP_1000  = 17'd67109;
   localparam int unsigned RECIP_SHIFT = 26;

   localparam logic [6:0]  RAMP_LAST = 7'd67;

   localparam logic [7:0]  VIVID_RESET  = 8'd160;
   localparam logic [7:0]  DARK_RESET   = 8'd40;
   localparam logic [7:0]  BRIGHT_RESET = 8'd220;

   typedef enum logic [1:0] {
      CSR_VIVID  = 2'd0,
      CSR_DARK   = 2'd1,
      CSR_BRIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      COL_RED     = 4'd1,
      COL_GREEN   = 4'd2,
      COL_YELLOW  = 4'd3,
      COL_BLUE    = 4'd4,
      COL_MAGENTA = 4'd5,
      COL_CYAN    = 4'd6,
      COL_WHITE   = 4'd7,
      COL_BLACK   = 4'd8
   } colour_type;

   typedef struct packed {
      logic [7:0] vivid;
      logic [7:0] dark;
      logic [7:0] bright;
   } thresholds_type;

   function automatic logic [6:0] ramp_glyph(input logic [6:0] pos);
      logic [6:0] code;
      case (pos)
         7'd0:  code = 7'h2E;
         7'd1:  code = 7'h27;
         7'd2:  code = 7'h60;
         7'd3:  code = 7'h5E;
         7'd4:  code = 7'h22;
         7'd5:  code = 7'h2C;
         7'd6:  code = 7'h3A;
         7'd7:  code = 7'h3B;
         7'd8:  code = 7'h49;
         7'd9:  code = 7'h6C;
         7'd10: code = 7'h21;
         7'd11: code = 7'h69;
         7'd12: code = 7'h7E;
         7'd13: code = 7'h2B;
         7'd14: code = 7'h5F;
         7'd15: code = 7'h2D;
         7'd16: code = 7'h3F;
         7'd17: code = 7'h5D;
         7'd18: code = 7'h5B;
         7'd19: code = 7'h7D;
         7'd20: code = 7'h7B;
         7'd21: code = 7'h31;
         7'd22: code = 7'h29;
         7'd23: code = 7'h28;
         7'd24: code = 7'h7C;
         7'd25: code = 7'h5C;
         7'd26: code = 7'h2F;
         7'd27: code = 7'h2A;
         7'd28: code = 7'h74;
         7'd29: code = 7'h66;
         7'd30: code = 7'h6A;
         7'd31: code = 7'h72;
         7'd32: code = 7'h78;
         7'd33: code = 7'h6E;
         7'd34: code = 7'h75;
         7'd35: code = 7'h76;
         7'd36: code = 7'h63;
         7'd37: code = 7'h7A;
         7'd38: code = 7'h58;
         7'd39: code = 7'h59;
         7'd40: code = 7'h55;
         7'd41: code = 7'h4A;
         7'd42: code = 7'h43;
         7'd43: code = 7'h4C;
         7'd44: code = 7'h51;
         7'd45: code = 7'h30;
         7'd46: code = 7'h4F;
         7'd47: code = 7'h5A;
         7'd48: code = 7'h6D;
         7'd49: code = 7'h77;
         7'd50: code = 7'h71;
         7'd51: code = 7'h70;
         7'd52: code = 7'h64;
         7'd53: code = 7'h62;
         7'd54: code = 7'h6B;
         7'd55: code = 7'h68;
         7'd56: code = 7'h61;
         7'd57: code = 7'h6F;
         7'd58: code = 7'h2A;
         7'd59: code = 7'h23;
         7'd60: code = 7'h4D;
         7'd61: code = 7'h57;
         7'd62: code = 7'h26;
         7'd63: code = 7'h38;
         7'd64: code = 7'h25;
         7'd65: code = 7'h42;
         7'd66: code = 7'h40;
         7'd67: code = 7'h24;
         default: code = 7'h24;
      endcase
      return code;
   endfunction

endpackage

// File: design/rpag_luma.sv
// Three-stage luma datapath: channel weighting, summation and division by 1000.
`timescale 1ns / 1ps

module rpag_luma import rpag_pkg::*; (
   input  logic         clock,
   input  logic         en,
   input  logic [7:0]   red,
   input  logic [7:0]   green,
   input  logic [7:0]   blue,
   output logic [7:0]   luma
);

   logic [16:0] red_prod_ff,   red_prod_in;
   logic [17:0] green_prod_ff, green_prod_in;
   logic [14:0] blue_prod_ff,  blue_prod_in;
   logic [17:0] sum_ff,        sum_in;
   logic [33:0] scaled_ff,     scaled_in;

   always_comb begin
      red_prod_in   = 17'({9'd0, red}) * 17'(LUMA_RED_WEIGHT);
      green_prod_in = 18'({10'd0, green}) * 18'(LUMA_GREEN_WEIGHT);
      blue_prod_in  = 15'({7'd0, blue}) * 15'(LUMA_BLUE_WEIGHT);
      sum_in        = 18'(red_prod_ff) + green_prod_ff + 18'(blue_prod_ff);
      scaled_in     = 34'(sum_ff) * 34'(RECIP_1000);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_prod_ff   <= red_prod_in;
         green_prod_ff <= green_prod_in;
         blue_prod_ff  <= blue_prod_in;
         sum_ff        <= sum_in;
         scaled_ff     <= scaled_in;
      end
   end

   assign luma = scaled_ff[RECIP_SHIFT +: 8];

endmodule

// File: design/rpag_ramp.sv
// Two-stage glyph lookup: scales brightness onto the ramp and selects the character.
`timescale 1ns / 1ps

module rpag_ramp import rpag_pkg::*; (
   input  logic         clock,
   input  logic         en,
   input  logic [7:0]   luma,
   output logic [7:0]   brightness,
   output logic [6:0]   glyph
);

   logic [14:0] scaled_ff, scaled_in;
   logic [7:0]  luma_ff;
   logic [14:0] quot_wide;
   logic [6:0]  pos;
   logic [6:0]  glyph_ff, glyph_in;
   logic [7:0]  brightness_ff;

   always_comb begin
      scaled_in = 15'({7'd0, luma}) * 15'(RAMP_LAST);
      // Exact floor of x / 255 for every product up to 255 * 67 = 17085.
      quot_wide = scaled_ff + 15'(scaled_ff[14:8]) + 15'd1;
      pos       = quot_wide[14:8];
      glyph_in  = ramp_glyph(pos);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         scaled_ff     <= scaled_in;
         luma_ff       <= luma;
         glyph_ff      <= glyph_in;
         brightness_ff <= luma_ff;
      end
   end

   assign brightness = brightness_ff;
   assign glyph      = glyph_ff;

endmodule

// File: design/rpag_colour.sv
// Palette colour path: dominant channel, vivid overrides, then dark and bright limits.
`timescale 1ns / 1ps

module rpag_colour import rpag_pkg::*; (
   input  logic           clock,
   input  logic           en,
   input  logic [7:0]     red,
   input  logic [7:0]     green,
   input  logic [7:0]     blue,
   input  thresholds_type thr,
   input  logic [7:0]     luma,
   output logic [3:0]     colour_index
);

   colour_type hue1_ff, hue1_in;
   colour_type hue2_ff;
   colour_type hue3_ff;
   colour_type final_ff, final_in;
   colour_type out_ff;
   logic       red_strong, green_strong, blue_strong;

   always_comb begin
      if (red >= green && red >= blue) begin
         hue1_in = COL_RED;
      end else if (green >= red && green >= blue) begin
         hue1_in = COL_GREEN;
      end else begin
         hue1_in = COL_BLUE;
      end
      red_strong   = red > thr.vivid;
      green_strong = green > thr.vivid;
      blue_strong  = blue > thr.vivid;
      if (red_strong && green_strong) begin
         hue1_in = COL_YELLOW;
      end
      if (green_strong && blue_strong) begin
         hue1_in = COL_CYAN;
      end
      if (red_strong && blue_strong) begin
         hue1_in = COL_MAGENTA;
      end
   end

   always_comb begin
      if (luma < thr.dark) begin
         final_in = COL_BLACK;
      end else if (luma > thr.bright) begin
         final_in = COL_WHITE;
      end else begin
         final_in = hue3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hue1_ff  <= hue1_in;
         hue2_ff  <= hue1_ff;
         hue3_ff  <= hue2_ff;
         final_ff <= final_in;
         out_ff   <= final_ff;
      end
   end

   assign colour_index = out_ff;

endmodule

// File: design/rgb_pixel_to_ascii_glyph_color.sv
// Top level of the RGB pixel to ASCII glyph and palette colour converter.
`timescale 1ns / 1ps

// Takes one RGB888 pixel per transfer and returns its integer luma, the ASCII glyph from a
// 68-step dark-to-bright ramp and a palette colour index. The five-stage pipeline accepts a
// pixel every clock cycle unless the output stalls, and delivers each result from its last stage;
// throughput is one pixel per cycle whenever the result side keeps rsp_tready high. The whole
// pipeline holds while a result waits, so req_tready follows rsp_tready when the output
// register is full. The three thresholds are written through the csr port, indices 0 vivid,
// 1 dark and 2 bright; other indices are ignored. Change them only while no pixel is in flight.

module rgb_pixel_to_ascii_glyph_color import rpag_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // red [7:0], green [15:8], blue [23:16]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,   // brightness [7:0], glyph [14:8], colour_index [18:15]
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   thresholds_type thr_ff, thr_in;
   logic [4:0]     valid_ff, valid_in;
   logic           advance;
   logic [7:0]     luma;
   logic [7:0]     brightness;
   logic [6:0]     glyph;
   logic [3:0]     colour_index;

   assign advance    = !valid_ff[4] || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      thr_in = thr_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_VIVID:  thr_in.vivid  = csr_wdata;
            CSR_DARK:   thr_in.dark   = csr_wdata;
            CSR_BRIGHT: thr_in.bright = csr_wdata;
            default:    thr_in = thr_ff;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = {valid_ff[3:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.vivid  <= VIVID_RESET;
         thr_ff.dark   <= DARK_RESET;
         thr_ff.bright <= BRIGHT_RESET;
         valid_ff      <= '0;
      end else begin
         thr_ff   <= thr_in;
         valid_ff <= valid_in;
      end
   end

   rpag_luma u_luma (
      .clock (clock),
      .en    (advance),
      .red   (req_tdata[7:0]),
      .green (req_tdata[15:8]),
      .blue  (req_tdata[23:16]),
      .luma  (luma)
   );

   rpag_ramp u_ramp (
      .clock      (clock),
      .en         (advance),
      .luma       (luma),
      .brightness (brightness),
      .glyph      (glyph)
   );

   rpag_colour u_colour (
      .clock        (clock),
      .en           (advance),
      .red          (req_tdata[7:0]),
      .green        (req_tdata[15:8]),
      .blue         (req_tdata[23:16]),
      .thr          (thr_ff),
      .luma         (luma),
      .colour_index (colour_index)
   );

   assign rsp_tvalid = valid_ff[4];
   assign rsp_tdata  = {5'd0, colour_index, glyph, brightness};

endmodule

// File: design/rpag_checker.sv
// Port-level checker for the RGB pixel to ASCII glyph block, bound to the top level.
`timescale 1ns / 1ps

module rpag_checker import rpag_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [23:0]  rsp_tdata
);

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result changed or vanished.");

   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("Input refused while the output could move.");

   a_colour_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[18:15] != 4'd0 && rsp_tdata[18:15] <= 4'd8))
      else $error("Colour index out of range.");

   a_glyph_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[14:8] >= 7'd32 && rsp_tdata[14:8] <= 7'd126))
      else $error("Glyph is not a printable character.");

endmodule

bind rgb_pixel_to_ascii_glyph_color rpag_checker u_rpag_checker (.*);
